// ----- design/char_lcd_command_sequencer_unit_defines.svh -----
// Assertion macros used by the checker file of the LCD command sequencer.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CLCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clcd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clcd assertion failed");

`endif

// ----- design/clcd_pkg.sv -----
// Shared types and constants of the LCD command sequencer.
package clcd_pkg;

  // Stream widths: fields packed from bit zero, tdata padded to whole bytes.
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // What the back end has to emit for one queued job.
  typedef enum logic [1:0] {
    JOB_READ,
    JOB_WRITE,
    JOB_WRITE_READ
  } job_kind_t;

  // Which hold time follows a write.
  typedef enum logic [1:0] {
    HOLD_CMD,
    HOLD_DATA,
    HOLD_CLEAR
  } hold_sel_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] bus_byte;
    hold_sel_t  hold;
  } job_t;

  typedef struct packed {
    logic [7:0]  setup_us;
    logic [7:0]  cmd_hold_us;
    logic [7:0]  data_hold_us;
    logic [15:0] clear_hold_us;
    logic [7:0]  func_set;
    logic [7:0]  disp_ctrl;
    logic [7:0]  entry_mode;
  } clcd_cfg_t;

endpackage

// ----- design/clcd_queue.sv -----
// Small job queue between the request front end and the bus back end.
module clcd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  clcd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output clcd_pkg::job_t head_job
);
  import clcd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            entries [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entries[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- design/clcd_front.sv -----
// Request front end: tracks the pending request and turns request and status words into bus jobs.
module clcd_front #(
  parameter int COLUMNS = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [2:0]       action,
  input  logic [7:0]       char_code,
  input  logic [5:0]       column,
  input  logic [1:0]       row,
  input  logic             busy_flag,
  input  clcd_pkg::clcd_cfg_t cfg,
  output logic             push,
  output clcd_pkg::job_t   push_job
);
  import clcd_pkg::*;

  localparam logic [2:0] ACT_INIT   = 3'd0;
  localparam logic [2:0] ACT_CHAR   = 3'd1;
  localparam logic [2:0] ACT_GOTO   = 3'd2;
  localparam logic [2:0] ACT_CLEAR  = 3'd3;
  localparam logic [2:0] ACT_STATUS = 3'd4;

  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_DDRAM   = 8'h80;
  localparam logic [7:0] LINE2_BASE  = 8'h40;
  localparam logic [7:0] COLS        = 8'(COLUMNS);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_CHAR,
    OP_GOTO,
    OP_CLEAR
  } op_t;

  op_t        op_r, op_nxt;
  logic [1:0] init_index_r, init_index_nxt;
  logic [7:0] pending_byte_r, pending_byte_nxt;
  logic       pending_is_data_r, pending_is_data_nxt;

  logic [7:0] col_c;
  logic [7:0] addr_c;

  // Clamp the column into 1..COLUMNS, then form the DDRAM address.
  always_comb begin
    col_c = {2'b00, column};
    if (col_c == 8'd0) begin
      col_c = 8'd1;
    end
    if (col_c > COLS) begin
      col_c = COLS;
    end
    addr_c = col_c - 8'd1;
    if (row == 2'd2) begin
      addr_c = addr_c + LINE2_BASE;
    end
    addr_c = CMD_DDRAM | {1'b0, addr_c[6:0]};
  end

  always_comb begin
    op_nxt              = op_r;
    init_index_nxt      = init_index_r;
    pending_byte_nxt    = pending_byte_r;
    pending_is_data_nxt = pending_is_data_r;
    push                = 1'b0;
    push_job            = '{kind: JOB_READ, rs: 1'b0, bus_byte: 8'd0, hold: HOLD_CMD};
    if (in_fire) begin
      if (action <= ACT_CLEAR) begin
        // A new request is dropped while another one is still pending.
        if (op_r == OP_NONE) begin
          push                = 1'b1;
          pending_is_data_nxt = 1'b0;
          unique case (action)
            ACT_INIT: begin
              op_nxt           = OP_INIT;
              init_index_nxt   = 2'd0;
              pending_byte_nxt = CMD_CLEAR;
            end
            ACT_CHAR: begin
              op_nxt              = OP_CHAR;
              pending_byte_nxt    = char_code;
              pending_is_data_nxt = 1'b1;
            end
            ACT_GOTO: begin
              op_nxt           = OP_GOTO;
              pending_byte_nxt = addr_c;
            end
            default: begin
              op_nxt           = OP_CLEAR;
              pending_byte_nxt = CMD_CLEAR;
            end
          endcase
        end
      end else if (action == ACT_STATUS && op_r != OP_NONE) begin
        push = 1'b1;
        if (!busy_flag) begin
          if (op_r == OP_INIT) begin
            unique case (init_index_r)
              2'd0: push_job = '{kind: JOB_WRITE_READ, rs: 1'b0, bus_byte: CMD_CLEAR,
                                 hold: HOLD_CLEAR};
              2'd1: push_job = '{kind: JOB_WRITE_READ, rs: 1'b0, bus_byte: cfg.func_set,
                                 hold: HOLD_CMD};
              2'd2: push_job = '{kind: JOB_WRITE_READ, rs: 1'b0, bus_byte: cfg.disp_ctrl,
                                 hold: HOLD_CMD};
              2'd3: push_job = '{kind: JOB_WRITE, rs: 1'b0, bus_byte: cfg.entry_mode,
                                 hold: HOLD_CMD};
            endcase
            if (init_index_r == 2'd3) begin
              op_nxt         = OP_NONE;
              init_index_nxt = 2'd0;
            end else begin
              init_index_nxt = init_index_r + 2'd1;
            end
          end else begin
            push_job.kind     = JOB_WRITE;
            push_job.rs       = pending_is_data_r;
            push_job.bus_byte = pending_byte_r;
            if (op_r == OP_CHAR) begin
              push_job.hold = HOLD_DATA;
            end else if (op_r == OP_CLEAR) begin
              push_job.hold = HOLD_CLEAR;
            end else begin
              push_job.hold = HOLD_CMD;
            end
            op_nxt              = OP_NONE;
            pending_is_data_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r              <= OP_NONE;
      init_index_r      <= 2'd0;
      pending_byte_r    <= 8'd0;
      pending_is_data_r <= 1'b0;
    end else begin
      op_r              <= op_nxt;
      init_index_r      <= init_index_nxt;
      pending_byte_r    <= pending_byte_nxt;
      pending_is_data_r <= pending_is_data_nxt;
    end
  end

endmodule

// ----- design/clcd_back.sv -----
// Bus back end: expands queued jobs into transaction words behind an output register.
module clcd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  clcd_pkg::job_t      head_job,
  output logic                pop,
  input  clcd_pkg::clcd_cfg_t cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                reg_select,
  output logic                read_not_write,
  output logic [7:0]          bus_byte,
  output logic [7:0]          pre_wait_us,
  output logic [15:0]         post_wait_us,
  output logic                last
);
  import clcd_pkg::*;

  logic        out_valid_r;
  logic        phase_r;
  logic        rs_r, rw_r, last_r;
  logic [7:0]  byte_r, pre_r;
  logic [15:0] post_r;
  logic        load;
  logic [15:0] hold_c;

  assign load = !out_valid_r || out_ready;
  // The job leaves the queue with its first word; a trailing status read
  // of an init step is sent from phase_r.
  assign pop  = load && !phase_r && head_valid;

  always_comb begin
    unique case (head_job.hold)
      HOLD_CMD:   hold_c = {8'd0, cfg.cmd_hold_us};
      HOLD_DATA:  hold_c = {8'd0, cfg.data_hold_us};
      HOLD_CLEAR: hold_c = cfg.clear_hold_us;
      default:    hold_c = {8'd0, cfg.cmd_hold_us};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (load) begin
      if (phase_r) begin
        out_valid_r <= 1'b1;
        phase_r     <= 1'b0;
      end else if (head_valid) begin
        out_valid_r <= 1'b1;
        phase_r     <= (head_job.kind == JOB_WRITE_READ);
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (phase_r || head_job.kind == JOB_READ) begin
        rs_r   <= 1'b0;
        rw_r   <= 1'b1;
        byte_r <= 8'd0;
        pre_r  <= 8'd0;
        post_r <= 16'd0;
        last_r <= 1'b1;
      end else begin
        rs_r   <= head_job.rs;
        rw_r   <= 1'b0;
        byte_r <= head_job.bus_byte;
        pre_r  <= cfg.setup_us;
        post_r <= hold_c;
        last_r <= (head_job.kind == JOB_WRITE);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign reg_select     = rs_r;
  assign read_not_write = rw_r;
  assign bus_byte       = byte_r;
  assign pre_wait_us    = pre_r;
  assign post_wait_us   = post_r;
  assign last           = last_r;

endmodule

// ----- design/char_lcd_command_sequencer_unit.sv -----
// Top level of the character LCD command sequencer.
//
//   channel  dir  handshake               payload
//   in_      in   in_tvalid / in_tready   in_tuser action, in_tdata request fields
//   out_     out  out_tvalid / out_tready out_tdata transaction, out_tlast
//   cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One input word is taken per cycle while the job queue has room; an init
// step ending in a write and a new status read yields two output words,
// every other job one. A job is registered in the queue, then in the
// output register. rst_n clears the pending request, the queue and the
// output register and loads the default timing and init words. A stalled
// output fills the queue before in_tready drops. cfg_ready is always high.
module char_lcd_command_sequencer_unit #(
  parameter int COLUMNS     = 40,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] char_code, [13:8] column, [15:14] row, [16] busy_flag
  input  logic [clcd_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [2:0] action
  input  logic [clcd_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] reg_select, [1] read_not_write, [9:2] bus_byte, [17:10] pre_wait_us,
  // [33:18] post_wait_us
  output logic [clcd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import clcd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SETUP      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CMD_HOLD   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_HOLD  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_HOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FUNC_SET   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DISP_CTRL  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_MODE = 3'd6;

  clcd_cfg_t cfg_r, cfg_nxt;
  logic      q_full, q_push, q_pop, q_head_valid;
  job_t      q_push_job, q_head_job;
  logic      in_fire;
  logic      rs, rw, last;
  logic [7:0]  bus_byte, pre_us;
  logic [15:0] post_us;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SETUP:      cfg_nxt.setup_us      = cfg_data[7:0];
        REG_CMD_HOLD:   cfg_nxt.cmd_hold_us   = cfg_data[7:0];
        REG_DATA_HOLD:  cfg_nxt.data_hold_us  = cfg_data[7:0];
        REG_CLEAR_HOLD: cfg_nxt.clear_hold_us = cfg_data;
        REG_FUNC_SET:   cfg_nxt.func_set      = cfg_data[7:0];
        REG_DISP_CTRL:  cfg_nxt.disp_ctrl     = cfg_data[7:0];
        REG_ENTRY_MODE: cfg_nxt.entry_mode    = cfg_data[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{setup_us: 8'd8, cmd_hold_us: 8'd39, data_hold_us: 8'd43,
                 clear_hold_us: 16'd2000, func_set: 8'h38, disp_ctrl: 8'h0e,
                 entry_mode: 8'h04};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  clcd_front #(
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .action   (in_tuser[2:0]),
    .char_code(in_tdata[7:0]),
    .column   (in_tdata[13:8]),
    .row      (in_tdata[15:14]),
    .busy_flag(in_tdata[16]),
    .cfg      (cfg_r),
    .push     (q_push),
    .push_job (q_push_job)
  );

  clcd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_job  (q_head_job)
  );

  clcd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_head_valid),
    .head_job      (q_head_job),
    .pop           (q_pop),
    .cfg           (cfg_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .reg_select    (rs),
    .read_not_write(rw),
    .bus_byte      (bus_byte),
    .pre_wait_us   (pre_us),
    .post_wait_us  (post_us),
    .last          (last)
  );

  assign out_tdata = {6'd0, post_us, pre_us, bus_byte, rw, rs};
  assign out_tlast = last;

endmodule

// ----- design/clcd_checker.sv -----
// Port-level checks of the LCD command sequencer and their bind.
`include "char_lcd_command_sequencer_unit_defines.svh"

module clcd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [clcd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tlast
);
  import clcd_pkg::*;

  // A stalled output word must not change.
  `CLCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // A status read drives no byte and no waits and always closes its input.
  `CLCD_ASSERT_NOW(a_read_clean, clk, rst_n, out_tvalid && out_tdata[1],
    out_tdata[33:2] == 32'd0 && out_tlast)

  // Data writes come only from a character request and end its results.
  `CLCD_ASSERT_NOW(a_data_write, clk, rst_n, out_tvalid && out_tdata[0],
    !out_tdata[1] && out_tlast)

  // An init write without last is followed at once by the next status read.
  `CLCD_ASSERT_NEXT(a_init_follow, clk, rst_n, out_tvalid && out_tready && !out_tlast,
    out_tvalid && out_tdata[1])

endmodule

bind char_lcd_command_sequencer_unit clcd_checker u_clcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
